// ===== rtl/bomm_pkg.sv =====
// Shared types and constants of the one-mismatch barcode matcher.
package bomm_pkg;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_KEY,
		ST_MUL,
		ST_HASH,
		ST_MOD,
		ST_READ,
		ST_CHECK,
		ST_FIN
	} state_t;

	// Commands
	localparam logic [1:0] CMD_MATCH   = 2'd0;
	localparam logic [1:0] CMD_EXACT   = 2'd1;
	localparam logic [1:0] CMD_VARIANT = 2'd2;
	localparam logic [1:0] CMD_CLEAR   = 2'd3;

	// Result status
	localparam logic [1:0] STS_OK        = 2'd0;
	localparam logic [1:0] STS_UNMATCHED = 2'd1;
	localparam logic [1:0] STS_COLLISION = 2'd2;
	localparam logic [1:0] STS_FULL      = 2'd3;

	// Register indexes
	localparam logic [2:0] REG_RUNWAY_CODE   = 3'd0;
	localparam logic [2:0] REG_RUNWAY_LENGTH = 3'd1;
	localparam logic [2:0] REG_BARCODE_LEN   = 3'd2;
	localparam logic [2:0] REG_KEY_LEN       = 3'd3;
	localparam logic [2:0] REG_STEM_BITS     = 3'd4;

	localparam logic [31:0] HASH_MULT   = 32'd2654435761;
	localparam logic [5:0]  READ_WINDOW = 6'd32;
	localparam logic [1:0]  BASE_MASK   = 2'b11;

endpackage

// ===== rtl/barcode_one_mismatch_matcher_core.sv =====
// Barcode matcher with one-substitution tolerance: keyed table, inserts and read matching.
//
// One item at a time. A command is taken only while the sequencer is idle; a finished
// result sits in an output register, so the next item can be taken while it waits.
// Every table probe runs through one shared hash unit (a 32x32 multiply, then a
// reduction to the table size) and one table port: each key passes a key-forming
// step, a multiply step and a hash step (which also forms the reciprocal quotient
// estimate), a reduction step (one correction) when TABLE_ENTRIES is not a power of
// two, then a read and a check per slot visited on the linear probe. A read match
// makes up to two runway attempts; an attempt whose runway or key region fails ends
// at its key-forming step. The result is posted from the finish state, and the next
// item is taken in the idle state. Exact insert is one probe; variant insert probes
// up to 3*(barcode_length-1) keys, and a skipped original base costs only a
// key-forming step. After reset, and for the clear command, the table is swept one
// slot per cycle while no item is taken (configuration writes are always taken). Only
// out-of-range register values are clamped: runway length to 2..MAX_RUNWAY_BASES, key
// length to 1..MAX_KEY_BASES, barcode length to 1..key length. Read lengths above 32
// count as 32. Non-match results carry zero barcode, distance and insert start.
module barcode_one_mismatch_matcher_core
	import bomm_pkg::*;
#(
	parameter int TABLE_ENTRIES    = 4096,
	parameter int MAX_KEY_BASES    = 16,
	parameter int MAX_RUNWAY_BASES = 15,
	parameter int BARCODE_ID_BITS  = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// command item
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 command,
	input  logic [31:0]                barcode_code,
	input  logic [BARCODE_ID_BITS-1:0] barcode_number,
	input  logic [63:0]                read_bases,
	input  logic [31:0]                read_invalid,
	input  logic [15:0]                read_length,
	// result item
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 status,
	output logic [BARCODE_ID_BITS-1:0] assigned_barcode,
	output logic                       mismatch_count,
	output logic [4:0]                 insert_offset,
	// register writes
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [2:0]                 cfg_index,
	input  logic [31:0]                cfg_data
);

	localparam int KW = 2 * MAX_KEY_BASES;
	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int IDW = BARCODE_ID_BITS;
	localparam bit HASH_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
	localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_ENTRIES - 1);
	localparam logic [31:0] TABLE_N32 = 32'(TABLE_ENTRIES);
	localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / 64'(TABLE_ENTRIES));

	// One table slot
	typedef struct packed {
		logic           valid;
		logic           ambig;
		logic           subst;
		logic [KW-1:0]  key;
		logic [IDW-1:0] id;
	} entry_t;

	// Configuration registers
	logic [29:0] runway_code_q;
	logic [3:0]  runway_length_q;
	logic [4:0]  barcode_length_q;
	logic [4:0]  key_length_q;
	logic [31:0] stem_key_bits_q;

	// Item registers
	logic [1:0]     cmd_q;
	logic [31:0]    code_q;
	logic [IDW-1:0] id_q;
	logic [63:0]    rb_q;
	logic [31:0]    inv_q;
	logic [5:0]     rlen_q;
	logic           cmd_active_q;

	// Sequencer and shared unit
	state_t         state_q, state_d;
	logic           att_q;
	logic [3:0]     pos_q;
	logic [1:0]     alt_q;
	logic [3:0]     rl_q;
	logic [KW-1:0]  key_q;
	logic [31:0]    prod_q;
	logic [31:0]    qhat_q;
	logic [AW-1:0]  idx_q;
	logic [AW-1:0]  probe_q;
	entry_t         rd_q;

	// Result staging and output register
	logic [1:0]     res_status_q;
	logic [IDW-1:0] res_bc_q;
	logic           res_mm_q;
	logic [4:0]     res_ist_q;
	logic           out_valid_q;
	logic [1:0]     status_q;
	logic [IDW-1:0] bc_q;
	logic           mm_q;
	logic [4:0]     ist_q;

	entry_t mem [TABLE_ENTRIES];

	function automatic logic [KW-1:0] kmask(input logic [4:0] n);
		logic [KW-1:0] m;
		m = '0;
		for (int i = 0; i < MAX_KEY_BASES; i++) begin
			m[2*i +: 2] = (5'(i) < n) ? BASE_MASK : 2'b00;
		end
		return m;
	endfunction

	// ---- effective lengths ----
	logic [4:0] kl, bcl;
	logic [3:0] rwl;
	always_comb begin
		kl = key_length_q;
		if (kl < 5'd1) kl = 5'd1;
		if (kl > 5'(MAX_KEY_BASES)) kl = 5'(MAX_KEY_BASES);
		bcl = barcode_length_q;
		if (bcl < 5'd1) bcl = 5'd1;
		if (bcl > kl) bcl = kl;
		rwl = runway_length_q;
		if (rwl < 4'd2) rwl = 4'd2;
		if (rwl > 4'(MAX_RUNWAY_BASES)) rwl = 4'(MAX_RUNWAY_BASES);
	end

	// ---- insert keys: full key and one-substitution variant ----
	logic [KW-1:0] fk, vk;
	logic [1:0]    orig;
	logic [3:0]    var_last;
	always_comb begin
		fk = ((code_q[KW-1:0] & kmask(bcl)) | stem_key_bits_q[KW-1:0]) & kmask(kl);
		orig = 2'b00;
		vk = fk;
		for (int i = 0; i < MAX_KEY_BASES; i++) begin
			if (4'(i) == pos_q) begin
				orig = fk[2*i +: 2];
				vk[2*i +: 2] = alt_q;
			end
		end
		var_last = 4'(bcl - 5'd1);
	end

	// ---- match attempt: runway check and key extraction ----
	logic [3:0]    rl;
	logic [29:0]   rw;
	logic [63:0]   rb_sh;
	logic [31:0]   inv_sh;
	logic [KW-1:0] mkey;
	logic          m_ok;
	always_comb begin
		rl = att_q ? rwl : rwl - 4'd1;
		rw = att_q ? runway_code_q : {2'b00, runway_code_q[29:2]};
		rb_sh = rb_q >> {rl, 1'b0};
		inv_sh = inv_q >> rl;
		m_ok = ({2'b00, rl} + {1'b0, kl}) <= rlen_q;
		for (int i = 0; i < 15; i++) begin
			if (4'(i) < rl && (inv_q[i] || rb_q[2*i +: 2] != rw[2*i +: 2])) m_ok = 1'b0;
		end
		mkey = '0;
		for (int i = 0; i < MAX_KEY_BASES; i++) begin
			if (5'(i) < kl) begin
				if (inv_sh[i]) m_ok = 1'b0;
				mkey[2*i +: 2] = rb_sh[2*i +: 2];
			end
		end
	end

	// ---- hash reduction: reciprocal quotient estimate, then one correction ----
	logic [63:0] recip_prod;
	logic [31:0] red_x, red_r;
	always_comb begin
		recip_prod = {32'd0, prod_q} * {32'd0, RECIP};
		red_x = prod_q - qhat_q * TABLE_N32;
		red_r = (red_x >= TABLE_N32) ? red_x - TABLE_N32 : red_x;
	end

	// ---- probe outcome ----
	logic hit, free, last_probe;
	always_comb begin
		hit = rd_q.valid && rd_q.key == key_q;
		free = !rd_q.valid;
		last_probe = probe_q == LAST_SLOT;
	end

	logic accept, out_free;
	assign accept = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// ---- sequencer outputs ----
	logic           mem_we, mem_re;
	entry_t         mem_wd;
	logic           key_load, att_next, var_adv, fin_load, next_probe;
	logic [KW-1:0]  key_d;
	logic [1:0]     fin_status;
	logic           fin_assign;
	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_wd = '0;
		key_load = 1'b0;
		key_d = fk;
		att_next = 1'b0;
		var_adv = 1'b0;
		fin_load = 1'b0;
		fin_status = STS_OK;
		fin_assign = 1'b0;
		next_probe = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (idx_q == LAST_SLOT && cmd_active_q) fin_load = 1'b1;
			end
			ST_KEY: begin
				case (cmd_q)
					CMD_MATCH: begin
						if (m_ok) begin
							key_load = 1'b1;
							key_d = mkey;
						end else if (!att_q) begin
							att_next = 1'b1;
						end else begin
							fin_load = 1'b1;
							fin_status = STS_UNMATCHED;
						end
					end
					CMD_EXACT: key_load = 1'b1;
					CMD_VARIANT: begin
						if (pos_q >= var_last) begin
							fin_load = 1'b1;
						end else if (alt_q == orig) begin
							var_adv = 1'b1;
						end else begin
							key_load = 1'b1;
							key_d = vk;
						end
					end
					default: fin_load = 1'b1;
				endcase
			end
			ST_READ: mem_re = 1'b1;
			ST_CHECK: begin
				if (!hit && !free) begin
					if (last_probe) begin
						if (cmd_q == CMD_MATCH) begin
							if (att_q) begin
								fin_load = 1'b1;
								fin_status = STS_UNMATCHED;
							end else begin
								att_next = 1'b1;
							end
						end else begin
							fin_load = 1'b1;
							fin_status = STS_FULL;
						end
					end else begin
						next_probe = 1'b1;
					end
				end else begin
					case (cmd_q)
						CMD_MATCH: begin
							if (hit && !rd_q.ambig) begin
								fin_load = 1'b1;
								fin_assign = 1'b1;
							end else if (!att_q) begin
								att_next = 1'b1;
							end else begin
								fin_load = 1'b1;
								fin_status = STS_UNMATCHED;
							end
						end
						CMD_EXACT: begin
							fin_load = 1'b1;
							if (free) begin
								mem_we = 1'b1;
								mem_wd = '{valid: 1'b1, ambig: 1'b0, subst: 1'b0,
									key: key_q, id: id_q};
							end else if (rd_q.ambig || rd_q.id != id_q) begin
								fin_status = STS_COLLISION;
							end
						end
						CMD_VARIANT: begin
							var_adv = 1'b1;
							if (free) begin
								mem_we = 1'b1;
								mem_wd = '{valid: 1'b1, ambig: 1'b0, subst: 1'b1,
									key: key_q, id: id_q};
							end else if (rd_q.id != id_q && rd_q.subst) begin
								mem_we = 1'b1;
								mem_wd = rd_q;
								mem_wd.ambig = 1'b1;
							end
						end
						default: fin_load = 1'b1;
					endcase
				end
			end
			default: ;
		endcase
	end

	// ---- next state ----
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (idx_q == LAST_SLOT) state_d = cmd_active_q ? ST_FIN : ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) state_d = (command == CMD_CLEAR) ? ST_CLEAR : ST_KEY;
			end
			ST_KEY: begin
				if (key_load) state_d = ST_MUL;
				else if (fin_load) state_d = ST_FIN;
			end
			ST_MUL: state_d = ST_HASH;
			ST_HASH: state_d = HASH_POW2 ? ST_READ : ST_MOD;
			ST_MOD: state_d = ST_READ;
			ST_READ: state_d = ST_CHECK;
			ST_CHECK: begin
				if (fin_load) state_d = ST_FIN;
				else if (next_probe) state_d = ST_READ;
				else state_d = ST_KEY;
			end
			ST_FIN: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---- table memory ----
	always_ff @(posedge clk) begin
		if (mem_we) mem[idx_q] <= mem_wd;
	end

	always_ff @(posedge clk) begin
		if (mem_re) rd_q <= mem[idx_q];
	end

	// ---- configuration ----
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			runway_code_q <= '0;
			runway_length_q <= 4'd2;
			barcode_length_q <= 5'd1;
			key_length_q <= 5'd1;
			stem_key_bits_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RUNWAY_CODE:   runway_code_q <= cfg_data[29:0];
				REG_RUNWAY_LENGTH: runway_length_q <= cfg_data[3:0];
				REG_BARCODE_LEN:   barcode_length_q <= cfg_data[4:0];
				REG_KEY_LEN:       key_length_q <= cfg_data[4:0];
				REG_STEM_BITS:     stem_key_bits_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---- control registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			idx_q <= '0;
			cmd_active_q <= 1'b0;
			out_valid_q <= 1'b0;
			att_q <= 1'b0;
			pos_q <= '0;
			alt_q <= '0;
			probe_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
				cmd_active_q <= 1'b0;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: idx_q <= (idx_q == LAST_SLOT) ? '0 : idx_q + 1'b1;
				ST_IDLE: begin
					if (accept) begin
						cmd_active_q <= 1'b1;
						idx_q <= '0;
						att_q <= 1'b0;
						pos_q <= '0;
						alt_q <= '0;
					end
				end
				ST_HASH: begin
					probe_q <= '0;
					if (HASH_POW2) idx_q <= prod_q[AW-1:0];
				end
				ST_MOD: idx_q <= red_r[AW-1:0];
				ST_CHECK: begin
					if (next_probe) begin
						probe_q <= probe_q + 1'b1;
						idx_q <= (idx_q == LAST_SLOT) ? '0 : idx_q + 1'b1;
					end
				end
				default: ;
			endcase
			if (att_next) att_q <= 1'b1;
			if (var_adv) begin
				alt_q <= alt_q + 2'd1;
				if (alt_q == BASE_MASK) pos_q <= pos_q + 4'd1;
			end
		end
	end

	// ---- payload registers ----
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= command;
			code_q <= barcode_code;
			id_q <= barcode_number;
			rb_q <= read_bases;
			inv_q <= read_invalid;
			rlen_q <= (read_length > 16'(READ_WINDOW)) ? READ_WINDOW : read_length[5:0];
		end
		if (key_load) begin
			key_q <= key_d;
			rl_q <= rl;
		end
		if (state_q == ST_MUL) prod_q <= 32'(key_q) * HASH_MULT;
		if (state_q == ST_HASH) qhat_q <= recip_prod[63:32];
		if (fin_load) begin
			res_status_q <= fin_status;
			res_bc_q <= fin_assign ? rd_q.id : '0;
			res_mm_q <= fin_assign ? rd_q.subst : 1'b0;
			res_ist_q <= fin_assign ? 5'({1'b0, rl_q} + bcl) : 5'd0;
		end
		if (state_q == ST_FIN && out_free) begin
			status_q <= res_status_q;
			bc_q <= res_bc_q;
			mm_q <= res_mm_q;
			ist_q <= res_ist_q;
		end
	end

	assign in_stall = state_q != ST_IDLE;
	assign out_valid = out_valid_q;
	assign status = status_q;
	assign assigned_barcode = bc_q;
	assign mismatch_count = mm_q;
	assign insert_offset = ist_q;

`ifndef ASSERT_OFF
	// a result appears only after the sequencer posts it
	a_post_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_FIN))
		else $error("result posted outside FIN");

	// non-assignments carry zero match fields
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != STS_OK) |->
		(assigned_barcode == '0 && insert_offset == 5'd0 && !mismatch_count))
		else $error("match fields set on a non-assignment");

	// a probe never visits a slot twice for one key
	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK && next_probe) |-> (probe_q != LAST_SLOT))
		else $error("probe wrapped the whole table");
`endif

endmodule

// ===== test/barcode_one_mismatch_matcher_core_tb.sv =====
// Self-checking testbench for the one-mismatch barcode matcher core.
`timescale 1ns / 100ps

module barcode_one_mismatch_matcher_core_tb;
	import bomm_pkg::*;

	localparam int TABLE_SLOTS = 4096;
	localparam int KEY_BASES_MAX = 16;
	localparam int RUNWAY_BASES_MAX = 15;
	localparam int ID_BITS = 12;
	localparam longint CYCLE_LIMIT = 2000000;
	localparam int SETTLE_CYCLES = 60; // covers a probe chain after the last result

	typedef struct packed {
		logic [1:0]         status;
		logic [ID_BITS-1:0] barcode;
		logic               subst;
		logic [4:0]         ins_start;
	} match_result_t;

	typedef struct {
		logic [31:0]        code;
		logic [ID_BITS-1:0] id;
	} barcode_ref_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [1:0]          command;
	logic [31:0]         barcode_code;
	logic [ID_BITS-1:0]  barcode_number;
	logic [63:0]         read_bases;
	logic [31:0]         read_invalid;
	logic [15:0]         read_length;
	logic                out_valid;
	logic                out_stall;
	logic [1:0]          status;
	logic [ID_BITS-1:0]  assigned_barcode;
	logic                mismatch_count;
	logic [4:0]          insert_offset;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [2:0]          cfg_index;
	logic [31:0]         cfg_data;

	// Shadow of the block's registers and key table
	logic [29:0] sh_runway_code;
	logic [3:0]  sh_runway_len;
	logic [4:0]  sh_bc_len;
	logic [4:0]  sh_key_len;
	logic [31:0] sh_stem_bits;
	bit          tab_valid [TABLE_SLOTS];
	bit          tab_ambig [TABLE_SLOTS];
	bit          tab_dist  [TABLE_SLOTS];
	logic [31:0] tab_key   [TABLE_SLOTS];
	logic [ID_BITS-1:0] tab_id [TABLE_SLOTS];

	match_result_t pending_results[$];
	barcode_ref_t  known_barcodes[$];
	int            mismatch_total;
	longint        cycle_count;
	bit            gaps_on;     // sender idling
	bit            calm;        // no idling on either side
	int            stall_left;

	barcode_one_mismatch_matcher_core uut (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Receiver stalls come in bursts; stretches of no stall in between
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
		end else begin
			out_stall <= !calm && ($urandom_range(0, 2) == 0);
			stall_left = $urandom_range(1, 19);
		end
	end

	// Result checker: oldest expectation against each accepted result
	always @(posedge clk) begin
		match_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: status %0d", status);
				mismatch_total++;
			end else begin
				exp_r = pending_results.pop_front();
				if (status !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, status);
					mismatch_total++;
				end
				if (assigned_barcode !== exp_r.barcode) begin
					$error("assigned_barcode: expected %0d, got %0d", exp_r.barcode,
						assigned_barcode);
					mismatch_total++;
				end
				if (mismatch_count !== exp_r.subst) begin
					$error("mismatch_count: expected %0d, got %0d", exp_r.subst,
						mismatch_count);
					mismatch_total++;
				end
				if (insert_offset !== exp_r.ins_start) begin
					$error("insert_offset: expected %0d, got %0d", exp_r.ins_start,
						insert_offset);
					mismatch_total++;
				end
			end
		end
	end

	// ---------------- predictor ----------------

	function automatic int key_bases();
		int k;
		k = sh_key_len;
		if (k < 1) k = 1;
		if (k > KEY_BASES_MAX) k = KEY_BASES_MAX;
		return k;
	endfunction

	function automatic int bc_bases();
		int b;
		b = sh_bc_len;
		if (b < 1) b = 1;
		if (b > key_bases()) b = key_bases();
		return b;
	endfunction

	function automatic int runway_bases();
		int r;
		r = sh_runway_len;
		if (r < 2) r = 2;
		if (r > RUNWAY_BASES_MAX) r = RUNWAY_BASES_MAX;
		return r;
	endfunction

	function automatic logic [31:0] bases_mask(int n);
		logic [63:0] m;
		m = (64'd1 << (2 * n)) - 64'd1;
		return m[31:0];
	endfunction

	function automatic logic [31:0] lookup_key(logic [31:0] code);
		return ((code & bases_mask(bc_bases())) | sh_stem_bits) & bases_mask(key_bases());
	endfunction

	// Linear probe from the multiplicative hash; slot -1 when the table is full
	function automatic void probe_table(input logic [31:0] key, output int slot,
		output bit hit);
		logic [31:0] prod;
		int idx;
		prod = key * HASH_MULT;
		hit = 1'b0;
		slot = -1;
		for (int n = 0; n < TABLE_SLOTS; n++) begin
			idx = (prod[11:0] + n) % TABLE_SLOTS;
			if (!tab_valid[idx]) begin
				slot = idx;
				return;
			end
			if (tab_key[idx] == key) begin
				slot = idx;
				hit = 1'b1;
				return;
			end
		end
	endfunction

	function automatic void fill_slot(int s, logic [31:0] key, logic [ID_BITS-1:0] id,
		bit subst);
		tab_valid[s] = 1'b1;
		tab_ambig[s] = 1'b0;
		tab_dist[s] = subst;
		tab_key[s] = key;
		tab_id[s] = id;
	endfunction

	function automatic logic [1:0] add_exact(logic [31:0] key, logic [ID_BITS-1:0] id);
		int s;
		bit hit;
		probe_table(key, s, hit);
		if (s < 0) return STS_FULL;
		if (!hit) begin
			fill_slot(s, key, id, 1'b0);
			return STS_OK;
		end
		if (tab_ambig[s] || tab_id[s] != id) return STS_COLLISION;
		return STS_OK;
	endfunction

	function automatic logic [1:0] add_variants(logic [31:0] key, logic [ID_BITS-1:0] id);
		logic [31:0] vk;
		logic [1:0] orig;
		int s;
		bit hit;
		for (int pos = 0; pos < bc_bases() - 1; pos++) begin
			orig = key[2*pos +: 2];
			for (int alt = 0; alt < 4; alt++) begin
				if (alt == orig) continue;
				vk = key;
				vk[2*pos +: 2] = alt[1:0];
				probe_table(vk, s, hit);
				if (s < 0) return STS_FULL;
				if (!hit) fill_slot(s, vk, id, 1'b1);
				else if (tab_id[s] != id && tab_dist[s]) tab_ambig[s] = 1'b1;
			end
		end
		return STS_OK;
	endfunction

	// Truncated runway first, then the full one
	function automatic match_result_t assign_read(logic [63:0] rb, logic [31:0] inv,
		logic [15:0] len);
		match_result_t r;
		int avail, rl, kl, s, p;
		logic [29:0] rw;
		logic [31:0] key;
		bit ok, hit;
		r = '0;
		r.status = STS_UNMATCHED;
		avail = (len > 32) ? 32 : len;
		kl = key_bases();
		for (int att = 0; att < 2; att++) begin
			rl = (att == 0) ? runway_bases() - 1 : runway_bases();
			rw = (att == 0) ? (sh_runway_code >> 2) : sh_runway_code;
			if (rl + kl > avail) continue;
			ok = 1'b1;
			for (int i = 0; i < rl; i++)
				if (inv[i] || rb[2*i +: 2] != rw[2*i +: 2]) ok = 1'b0;
			if (!ok) continue;
			key = '0;
			for (int i = 0; i < kl; i++) begin
				p = rl + i;
				if (inv[p]) ok = 1'b0;
				key[2*i +: 2] = rb[2*p +: 2];
			end
			if (!ok) continue;
			probe_table(key, s, hit);
			if (s < 0 || !hit || tab_ambig[s]) continue;
			r.status = STS_OK;
			r.barcode = tab_id[s];
			r.subst = tab_dist[s];
			r.ins_start = 5'(rl + bc_bases());
			return r;
		end
		return r;
	endfunction

	// ---------------- drivers ----------------

	task automatic send_item(logic [1:0] cmd, logic [31:0] code, logic [ID_BITS-1:0] id,
		logic [63:0] rb, logic [31:0] inv, logic [15:0] len);
		match_result_t r;
		if (gaps_on && !calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		barcode_code <= code;
		barcode_number <= id;
		read_bases <= rb;
		read_invalid <= inv;
		read_length <= len;
		do @(posedge clk); while (in_stall);
		r = '0;
		case (cmd)
			CMD_CLEAR: begin
				for (int i = 0; i < TABLE_SLOTS; i++) tab_valid[i] = 1'b0;
				known_barcodes.delete();
			end
			CMD_EXACT: begin
				r.status = add_exact(lookup_key(code), id);
				known_barcodes.push_back('{code, id});
			end
			CMD_VARIANT: r.status = add_variants(lookup_key(code), id);
			default: r = assign_read(rb, inv, len);
		endcase
		pending_results.push_back(r);
	endtask

	// Sender idle until every result is back, then let the sequencer settle
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_RUNWAY_CODE:   sh_runway_code = data[29:0];
			REG_RUNWAY_LENGTH: sh_runway_len = data[3:0];
			REG_BARCODE_LEN:   sh_bc_len = data[4:0];
			REG_KEY_LEN:       sh_key_len = data[4:0];
			REG_STEM_BITS:     sh_stem_bits = data;
			default: ;
		endcase
	endtask

	// All registers, then a fresh table
	task automatic load_setting(logic [29:0] rc, logic [3:0] rl, logic [4:0] bl,
		logic [4:0] kl, logic [31:0] stem);
		drain();
		write_reg(REG_RUNWAY_CODE, {2'b00, rc});
		write_reg(REG_RUNWAY_LENGTH, {28'd0, rl});
		write_reg(REG_BARCODE_LEN, {27'd0, bl});
		write_reg(REG_KEY_LEN, {27'd0, kl});
		write_reg(REG_STEM_BITS, stem);
		cfg_valid <= 1'b0;
		send_item(CMD_CLEAR, $urandom, ID_BITS'($urandom), {$urandom, $urandom}, $urandom,
			16'($urandom));
	endtask

	// Read that carries the runway (truncated or full) and then the given key
	function automatic logic [63:0] read_for_key(logic [31:0] key, bit truncated);
		logic [63:0] rb;
		logic [29:0] rw;
		int rl;
		rb = {$urandom, $urandom};
		rl = truncated ? runway_bases() - 1 : runway_bases();
		rw = truncated ? (sh_runway_code >> 2) : sh_runway_code;
		for (int i = 0; i < rl; i++) rb[2*i +: 2] = rw[2*i +: 2];
		for (int i = 0; i < key_bases(); i++) rb[2*(rl + i) +: 2] = key[2*i +: 2];
		return rb;
	endfunction

	task automatic send_read(logic [31:0] key, bit truncated, logic [31:0] inv,
		logic [15:0] len);
		send_item(CMD_MATCH, $urandom, ID_BITS'($urandom), read_for_key(key, truncated),
			inv, len);
	endtask

	// ---------------- tests ----------------

	// Hand-picked inserts and reads under one mid-size setting
	task automatic test_directed();
		logic [31:0] k;
		load_setting(30'h1B, 4'd4, 5'd4, 5'd6, 32'h0000_0600);
		send_item(CMD_EXACT, 32'h0, 12'd0, '0, '0, '0);
		send_item(CMD_EXACT, 32'hFFFF_FFFF, 12'd4095, '1, '1, '1);
		// same barcode again is fine, a different one collides
		send_item(CMD_EXACT, 32'h0000_00FF, 12'd4095, '0, '0, '0);
		send_item(CMD_EXACT, 32'h0, 12'd7, '0, '0, '0);
		// variants of two barcodes two bases apart clash and turn ambiguous
		send_item(CMD_VARIANT, 32'h0, 12'd0, '0, '0, '0);
		send_item(CMD_VARIANT, 32'h5, 12'd9, '0, '0, '0);
		send_item(CMD_EXACT, 32'h5, 12'd9, '0, '0, '0);
		send_item(CMD_VARIANT, 32'hFF, 12'd4095, '0, '0, '0);
		k = lookup_key(32'h0);
		send_read(k, 1'b1, '0, 16'd32);            // exact, truncated runway
		send_read(k, 1'b0, '0, 16'd32);            // exact, full runway
		send_read(lookup_key(32'h5), 1'b0, '0, 16'hFFFF);
		send_read(lookup_key(32'h1), 1'b0, '0, 16'd32);  // ambiguous variant
		send_read(lookup_key(32'h3F), 1'b1, '0, 16'd32); // one-base variant of 0xFF
		send_read(k, 1'b0, 32'h1, 16'd32);         // invalid base in the runway
		send_read(k, 1'b0, 32'h10, 16'd32);        // invalid base in the key
		send_read(k, 1'b0, '0, 16'd9);             // only the truncated attempt fits
		send_read(k, 1'b1, '0, 16'd9);
		send_read(k, 1'b0, '0, 16'd0);             // empty read
		send_item(CMD_MATCH, '0, '0, '1, '1, 16'd32);
		send_item(CMD_MATCH, '0, '0, '1, '0, 16'd33);
		send_read(32'hFFFF_FFFF, 1'b0, '0, 16'd32); // key never inserted
		send_item(CMD_CLEAR, '0, '0, '0, '0, '0);
		send_read(k, 1'b0, '0, 16'd32);
	endtask

	// Random traffic, mostly reads built from inserted barcodes
	task automatic test_random_traffic(int items);
		int pick, sel;
		logic [31:0] key, inv;
		logic [15:0] len;
		for (int n = 0; n < items; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				send_item(CMD_CLEAR, $urandom, ID_BITS'($urandom), {$urandom, $urandom},
					$urandom, 16'($urandom));
			end else if (pick < 18 || known_barcodes.size() == 0) begin
				send_item(CMD_EXACT, $urandom, ID_BITS'($urandom), {$urandom, $urandom},
					$urandom, 16'($urandom));
			end else if (pick < 28) begin
				sel = $urandom_range(0, known_barcodes.size() - 1);
				send_item(CMD_VARIANT, (pick < 24) ? known_barcodes[sel].code : $urandom,
					(pick < 26) ? known_barcodes[sel].id : ID_BITS'($urandom),
					{$urandom, $urandom}, $urandom, 16'($urandom));
			end else if (pick < 38) begin
				send_item(CMD_MATCH, $urandom, ID_BITS'($urandom), {$urandom, $urandom},
					$urandom,
					($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(0, 40)));
			end else begin
				sel = $urandom_range(0, known_barcodes.size() - 1);
				key = lookup_key(known_barcodes[sel].code);
				// one substitution inside the barcode part
				if ($urandom_range(0, 9) < 4) begin
					sel = $urandom_range(0, bc_bases() - 1);
					key[2*sel +: 2] = key[2*sel +: 2] ^ 2'($urandom_range(1, 3));
				end
				inv = ($urandom_range(0, 9) == 0) ? (32'h1 << $urandom_range(0, 31)) : '0;
				len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 32))
					: 16'($urandom_range(32, 65535));
				send_read(key, 1'($urandom_range(0, 1)), inv, len);
			end
		end
	endtask

	// Sender holds off mid-traffic until every result is back
	task automatic test_hold_off();
		test_random_traffic(40);
		drain();
		test_random_traffic(40);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_MATCH;
		barcode_code = '0;
		barcode_number = '0;
		read_bases = '0;
		read_invalid = '0;
		read_length = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_RUNWAY_CODE;
		cfg_data = '0;
		mismatch_total = 0;
		cycle_count = 0;
		stall_left = 0;
		gaps_on = 1'b0;
		calm = 1'b0;
		sh_runway_code = '0;
		sh_runway_len = 4'd2;
		sh_bc_len = 5'd1;
		sh_key_len = 5'd1;
		sh_stem_bits = '0;
		for (int i = 0; i < TABLE_SLOTS; i++) tab_valid[i] = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		gaps_on = 1'b1;
		// widest setting
		load_setting(30'h3FFF_FFFF, 4'd15, 5'd16, 5'd16, $urandom);
		test_random_traffic(90);
		// narrowest setting
		load_setting(30'h0, 4'd2, 5'd1, 5'd1, 32'h0);
		test_random_traffic(90);
		// out-of-range values are clamped
		load_setting(30'($urandom), 4'd1, 5'd0, 5'd31, $urandom);
		test_random_traffic(90);
		load_setting(30'($urandom), 4'd0, 5'd20, 5'd9, $urandom & 32'hFFFC_0000);
		test_random_traffic(90);
		load_setting(30'($urandom), 4'($urandom_range(2, 15)), 5'($urandom_range(1, 8)),
			5'($urandom_range(8, 16)), $urandom & 32'hFFFF_0000);
		test_hold_off();
		load_setting(30'($urandom), 4'($urandom_range(2, 15)), 5'($urandom_range(1, 16)),
			5'($urandom_range(1, 16)), $urandom);
		test_random_traffic(90);
		// closing stretch without idling
		calm = 1'b1;
		load_setting(30'($urandom), 4'($urandom_range(2, 15)), 5'($urandom_range(2, 10)),
			5'($urandom_range(10, 16)), 32'h0);
		test_random_traffic(150);

		drain();
		if (mismatch_total == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== barcode_one_mismatch_matcher_core.f =====
rtl/bomm_pkg.sv
rtl/barcode_one_mismatch_matcher_core.sv
test/barcode_one_mismatch_matcher_core_tb.sv
